// ===== sv/tscw_pkg.sv =====
// ----------------------------------------------------------------------------
// tscw_pkg
// Shared types and constants of the timestamp coincidence window.
// ----------------------------------------------------------------------------
package tscw_pkg;

  localparam int STORE_DEPTH   = 64;
  localparam int TRIGGER_DEPTH = 16;
  localparam int TIME_BITS     = 48;

  localparam int TS_IN_W   = 48;
  localparam int WIDTH_W   = 32;
  localparam int CMP_W     = (TIME_BITS > WIDTH_W) ? TIME_BITS : WIDTH_W;
  localparam int COUNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int TCOUNT_W  = $clog2(TRIGGER_DEPTH + 1);
  localparam int TIDX_W    = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;
  localparam int KEY_W     = 14;

  typedef logic [TIME_BITS-1:0] ts_t;
  typedef logic [KEY_W-1:0]     key_t;

  typedef enum logic [1:0] {
    CT_TRIGGER = 2'd0,
    CT_WIDTH   = 2'd1,
    CT_ANALOG  = 2'd2,
    CT_UNSET   = 2'd3
  } corr_t;

  typedef enum logic [1:0] {
    MD_CHECK = 2'd0,
    MD_POP   = 2'd1,
    MD_CLEAR = 2'd2,
    MD_ADD   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNSET     = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TRIG_FULL = 3'd4
  } status_t;

  typedef enum logic {
    REG_CORR_TYPE = 1'b0,
    REG_WINDOW    = 1'b1
  } reg_idx_t;

  // Per-cycle command to every store cell
  typedef struct packed {
    logic ins;   // sorted insert of the current timestamp
    logic shl;   // drop cell 0, everything moves one place left
  } cell_ctl_t;

endpackage

// ===== sv/tscw_if.sv =====
// ----------------------------------------------------------------------------
// tscw_if
// Valid/ready channels for hit items and result items.
// ----------------------------------------------------------------------------
interface tscw_in_if import tscw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [TS_IN_W-1:0] timestamp;
  logic [3:0]         crate;
  logic [4:0]         module_slot;
  logic [4:0]         channel;

  modport source(output valid, mode, timestamp, crate, module_slot, channel,
                 input ready);
  modport sink(input valid, mode, timestamp, crate, module_slot, channel,
               output ready);
endinterface

interface tscw_out_if;
  logic       valid;
  logic       ready;
  logic       in_window;
  logic [2:0] status;

  modport source(output valid, in_window, status, input ready);
  modport sink(input valid, in_window, status, output ready);
endinterface

// ===== sv/tscw_cell.sv =====
// ----------------------------------------------------------------------------
// tscw_cell
// One slot of the sorted timestamp chain.
// ----------------------------------------------------------------------------
module tscw_cell import tscw_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  ts_t       ts,
  input  ts_t       left_value,
  input  logic      left_le,
  input  ts_t       right_value,
  output ts_t       value,
  output logic      le
);

  ts_t value_next;

  // le is a prefix over the chain since the contents stay ascending
  assign le = occupied && (value <= ts);

  always_comb begin
    value_next = value;
    if (ctl.ins) begin
      if (!le) begin
        value_next = left_le ? ts : left_value;
      end
    end else if (ctl.shl) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== sv/tscw_trig_cell.sv =====
// ----------------------------------------------------------------------------
// tscw_trig_cell
// One entry of the trigger channel set with its match compare.
// ----------------------------------------------------------------------------
module tscw_trig_cell import tscw_pkg::*; (
  input  logic clk,
  input  logic we,
  input  logic occupied,
  input  key_t key,
  output logic hit
);

  key_t stored;

  assign hit = occupied && (stored == key);

  always_ff @(posedge clk) begin
    if (we) begin
      stored <= key;
    end
  end

endmodule

// ===== sv/timestamp_coincidence_window.sv =====
// ----------------------------------------------------------------------------
// timestamp_coincidence_window
// Coincidence-window event builder over a sorted chain of timestamp cells.
// ----------------------------------------------------------------------------
// An item is registered when taken and executed once the output register is
// free; no further item is taken until it executes. Between executes the
// registered maximum of the store (an AND-OR over the cells) follows the
// previous update. Inserts, pops and trigger lookups all finish in the execute
// cycle: each store cell compares and shifts in parallel with its neighbors.
// A result waits in the output register while the next item is taken.
module timestamp_coincidence_window import tscw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [WIDTH_W-1:0] cfg_data,
  tscw_in_if.sink            item,
  tscw_out_if.source         result
);

  corr_t              corr_type;
  logic [WIDTH_W-1:0] window_width;

  logic               busy;
  mode_t              mode_q;
  ts_t                ts_q;
  key_t               key_q;

  logic               out_valid;
  logic               out_in_window;
  status_t            out_status;

  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [TCOUNT_W-1:0] trig_count;
  logic [TCOUNT_W-1:0] trig_count_next;

  ts_t                cell_value [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] cell_le;
  logic [STORE_DEPTH-1:0] occ;
  cell_ctl_t          ctl;
  ts_t                max_q;
  ts_t                max_sel;

  logic [TRIGGER_DEPTH-1:0] trig_occ;
  logic [TRIGGER_DEPTH-1:0] trig_hit;
  logic [TRIGGER_DEPTH-1:0] trig_we;
  logic                     trig_write;

  logic               exec;
  ts_t                top;
  ts_t                diff;
  logic               near;
  logic               any_hit;
  logic               res_in_window;
  status_t            res_status;

  assign item.ready = !busy && !rst;
  assign exec       = busy && (!out_valid || result.ready);

  assign result.valid     = out_valid;
  assign result.in_window = out_in_window;
  assign result.status    = out_status;

  // ---------------- store chain ----------------
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      occ[i] = (COUNT_W'(i) < count);
    end
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    tscw_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ[i]),
      .ts          (ts_q),
      .left_value  ((i == 0) ? ts_t'(0) : cell_value[(i == 0) ? 0 : i - 1]),
      .left_le     ((i == 0) ? 1'b1 : cell_le[(i == 0) ? 0 : i - 1]),
      .right_value ((i == STORE_DEPTH - 1) ? ts_t'(0)
                    : cell_value[(i == STORE_DEPTH - 1) ? i : i + 1]),
      .value       (cell_value[i]),
      .le          (cell_le[i])
    );
  end

  // last occupied cell holds the maximum
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (occ[i] && ((i == STORE_DEPTH - 1) || !occ[(i == STORE_DEPTH - 1) ? i : i + 1])) begin
        max_sel = max_sel | cell_value[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    max_q <= max_sel;
  end

  // ---------------- trigger set ----------------
  always_comb begin
    for (int i = 0; i < TRIGGER_DEPTH; i++) begin
      trig_occ[i] = (TCOUNT_W'(i) < trig_count);
      trig_we[i]  = trig_write && (trig_count[TIDX_W-1:0] == TIDX_W'(i));
    end
  end

  for (genvar i = 0; i < TRIGGER_DEPTH; i++) begin : g_trig
    tscw_trig_cell u_trig (
      .clk      (clk),
      .we       (trig_we[i]),
      .occupied (trig_occ[i]),
      .key      (key_q),
      .hit      (trig_hit[i])
    );
  end

  assign any_hit = |trig_hit;

  // ---------------- execute ----------------
  assign top  = (corr_type == CT_WIDTH) ? max_q : cell_value[0];
  assign diff = (ts_q >= top) ? (ts_q - top) : (top - ts_q);
  assign near = (CMP_W'(diff) < CMP_W'(window_width));

  always_comb begin
    ctl             = '0;
    count_next      = count;
    trig_count_next = trig_count;
    trig_write      = 1'b0;
    res_in_window   = 1'b0;
    res_status      = ST_OK;
    case (mode_q)
      MD_CHECK: begin
        if (corr_type == CT_TRIGGER || corr_type == CT_WIDTH) begin
          res_in_window = (count == '0) || near;
          if (count >= COUNT_W'(STORE_DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            ctl.ins    = exec;
            count_next = count + COUNT_W'(1);
          end
        end else if (corr_type == CT_ANALOG) begin
          res_in_window = any_hit;
        end else begin
          res_status = ST_UNSET;
        end
      end
      MD_POP: begin
        if (corr_type == CT_UNSET) begin
          res_status = ST_UNSET;
        end else if (corr_type != CT_ANALOG) begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            ctl.shl    = exec && (corr_type == CT_TRIGGER);
            count_next = count - COUNT_W'(1);
          end
        end
      end
      MD_CLEAR: begin
        if (corr_type == CT_UNSET) begin
          res_status = ST_UNSET;
        end else if (corr_type != CT_ANALOG) begin
          count_next = '0;
        end
      end
      MD_ADD: begin
        if (!any_hit) begin
          if (trig_count >= TCOUNT_W'(TRIGGER_DEPTH)) begin
            res_status = ST_TRIG_FULL;
          end else begin
            trig_write      = exec;
            trig_count_next = trig_count + TCOUNT_W'(1);
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_type    <= CT_UNSET;
      window_width <= '0;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      count        <= '0;
      trig_count   <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_CORR_TYPE: corr_type    <= corr_t'(cfg_data[1:0]);
          REG_WINDOW:    window_width <= cfg_data;
          default:       corr_type    <= corr_type;
        endcase
      end
      if (item.valid && item.ready) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end
      if (exec) begin
        out_valid  <= 1'b1;
        count      <= count_next;
        trig_count <= trig_count_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      mode_q <= mode_t'(item.mode);
      ts_q   <= ts_t'(item.timestamp);
      key_q  <= {item.crate, item.module_slot, item.channel};
    end
    if (exec) begin
      out_in_window <= res_in_window;
      out_status    <= res_status;
    end
  end

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STORE_DEPTH))
    else $error("store count beyond depth");

  a_trig_bound: assert property (@(posedge clk) disable iff (rst)
    trig_count <= TCOUNT_W'(TRIGGER_DEPTH))
    else $error("trigger count beyond depth");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (!$past(exec) && !$past(rst) && count != '0) |-> (cell_value[0] <= max_q))
    else $error("store chain out of order");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> (out_valid && !busy))
    else $error("executed item left no result");

endmodule
